[rtl/mcrc16_pkg.sv]
`timescale 1ns / 1ps

package mcrc16_pkg;

   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_F = 8'h46;
   localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_F = 8'h66;
   localparam logic [3:0]  NIBBLE_TEN   = 4'd10;
   localparam int          BYTE_BITS    = 8;

   typedef struct packed {
      logic [15:0] crc;
      logic [3:0]  held_nibble;
      logic        second_digit;
      logic        error_seen;
   } state_type;

   localparam state_type STATE_INIT = '{
      crc:          CRC_INIT,
      held_nibble:  4'd0,
      second_digit: 1'b0,
      error_seen:   1'b0
   };

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] digit_base;
      logic [6:0] letter_base;
      digit_base  = CHAR_ZERO[6:0];
      letter_base = CHAR_LOWER_A[6:0] - {3'd0, NIBBLE_TEN};
      if (nib < NIBBLE_TEN) begin
         return digit_base + {3'd0, nib};
      end else begin
         return letter_base + {3'd0, nib};
      end
   endfunction

endpackage

[rtl/mcrc16_if.sv]
`timescale 1ns / 1ps

interface mcrc16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;
   logic       last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

interface mcrc16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] crc_value;
   logic [6:0]  text_char0;
   logic [6:0]  text_char1;
   logic [6:0]  text_char2;
   logic [6:0]  text_char3;
   logic        bad_digit;
   logic        odd_count;

   modport source (output valid, output crc_value, output text_char0, output text_char1,
                   output text_char2, output text_char3, output bad_digit,
                   output odd_count, input ready);
   modport sink   (input valid, input crc_value, input text_char0, input text_char1,
                   input text_char2, input text_char3, input bad_digit,
                   input odd_count, output ready);
endinterface

[rtl/mcrc16_step.sv]
`timescale 1ns / 1ps

module mcrc16_step (
   input  mcrc16_pkg::state_type state_cur,
   input  logic [7:0]            ascii_char,
   output mcrc16_pkg::state_type state_nxt
);

   logic [3:0]  nib;
   logic        digit_ok;
   logic [15:0] crc_work;

   always_comb begin
      digit_ok = 1'b1;
      if (ascii_char >= mcrc16_pkg::CHAR_ZERO && ascii_char <= mcrc16_pkg::CHAR_NINE) begin
         nib = ascii_char[3:0];
      end else if ((ascii_char >= mcrc16_pkg::CHAR_UPPER_A &&
                    ascii_char <= mcrc16_pkg::CHAR_UPPER_F) ||
                   (ascii_char >= mcrc16_pkg::CHAR_LOWER_A &&
                    ascii_char <= mcrc16_pkg::CHAR_LOWER_F)) begin
         nib = ascii_char[3:0] + 4'd9;
      end else begin
         nib      = 4'd0;
         digit_ok = 1'b0;
      end
   end

   always_comb begin
      crc_work = state_cur.crc ^ {8'd0, state_cur.held_nibble, nib};
      for (int b = 0; b < mcrc16_pkg::BYTE_BITS; b++) begin
         if (crc_work[0]) begin
            crc_work = (crc_work >> 1) ^ mcrc16_pkg::CRC_POLY;
         end else begin
            crc_work = crc_work >> 1;
         end
      end
   end

   always_comb begin
      state_nxt            = state_cur;
      state_nxt.error_seen = state_cur.error_seen | ~digit_ok;
      if (!state_cur.second_digit) begin
         state_nxt.held_nibble  = nib;
         state_nxt.second_digit = 1'b1;
      end else begin
         state_nxt.crc          = crc_work;
         state_nxt.held_nibble  = 4'd0;
         state_nxt.second_digit = 1'b0;
      end
   end

endmodule

[rtl/modbus_crc16_hex_ascii.sv]
`timescale 1ns / 1ps

// channel   dir  fields                                          transfer
// req_chan  in   ascii_char[7:0], last_char                      valid & ready
// rsp_chan  out  crc_value[15:0], text_char0..3[6:0],            valid & ready
//                bad_digit, odd_count
//
// One character per cycle unless req_chan stalls; the CRC byte update is one combinational pass.
// A result appears in the cycle after the character marked last is taken.
// Synchronous reset restores CRC 0xFFFF and clears pairing and error state.
// The result register holds while rsp_chan is stalled; req_chan stalls only
// when that register is full and not being taken.

module modbus_crc16_hex_ascii (
   input logic          clock,
   input logic          reset,
   mcrc16_req_if.sink   req_chan,
   mcrc16_rsp_if.source rsp_chan
);

   mcrc16_pkg::state_type state_ff, state_in, state_nxt;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] crc_ff, crc_in;
   logic        bad_ff, bad_in;
   logic        odd_ff, odd_in;
   logic        req_fire;
   logic        rsp_fire;
   logic        emit;

   mcrc16_step u_step (
      .state_cur  (state_ff),
      .ascii_char (req_chan.ascii_char),
      .state_nxt  (state_nxt)
   );

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign rsp_fire       = rsp_valid_ff & rsp_chan.ready;
   assign emit           = req_fire & req_chan.last_char;

   always_comb begin
      state_in = state_ff;
      if (req_fire) begin
         state_in = req_chan.last_char ? mcrc16_pkg::STATE_INIT : state_nxt;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_fire;
      crc_in       = crc_ff;
      bad_in       = bad_ff;
      odd_in       = odd_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         crc_in       = state_nxt.crc;
         bad_in       = state_nxt.error_seen;
         odd_in       = state_nxt.second_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcrc16_pkg::STATE_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      bad_ff <= bad_in;
      odd_ff <= odd_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.crc_value  = crc_ff;
   assign rsp_chan.text_char0 = mcrc16_pkg::hex_char(crc_ff[7:4]);
   assign rsp_chan.text_char1 = mcrc16_pkg::hex_char(crc_ff[3:0]);
   assign rsp_chan.text_char2 = mcrc16_pkg::hex_char(crc_ff[15:12]);
   assign rsp_chan.text_char3 = mcrc16_pkg::hex_char(crc_ff[11:8]);
   assign rsp_chan.bad_digit  = bad_ff;
   assign rsp_chan.odd_count  = odd_ff;

   a_emit_valid : assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("result not presented after last character");

   a_emit_clears : assert property (@(posedge clock) disable iff (reset)
      emit |=> state_ff == mcrc16_pkg::STATE_INIT)
      else $error("state not restored after message end");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_valid_ff && !rsp_chan.ready)
      else $error("input stalled without a pending result");

   a_pairing : assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_chan.last_char |=> state_ff.second_digit != $past(state_ff.second_digit))
      else $error("digit pairing did not advance");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [15:0] crc_value;
      logic [6:0]  text_char0;
      logic [6:0]  text_char1;
      logic [6:0]  text_char2;
      logic [6:0]  text_char3;
      logic        bad_digit;
      logic        odd_count;
   } crc_result_type;

   class crc_scoreboard;
      logic [15:0]    crc_acc;
      logic [3:0]     high_nibble;
      bit             low_next;
      bit             bad_seen;
      crc_result_type crc_results_q[$];
      int             errors;

      function new();
         errors = 0;
         clear_message();
      endfunction

      function void clear_message();
         crc_acc     = mcrc16_pkg::CRC_INIT;
         high_nibble = 4'd0;
         low_next    = 1'b0;
         bad_seen    = 1'b0;
      endfunction

      function logic [3:0] digit_value(input logic [7:0] ch, output bit ok);
         ok = 1'b1;
         if (ch >= mcrc16_pkg::CHAR_ZERO && ch <= mcrc16_pkg::CHAR_NINE) begin
            return 4'(ch - mcrc16_pkg::CHAR_ZERO);
         end
         if (ch >= mcrc16_pkg::CHAR_UPPER_A && ch <= mcrc16_pkg::CHAR_UPPER_F) begin
            return 4'(ch - mcrc16_pkg::CHAR_UPPER_A + 8'd10);
         end
         if (ch >= mcrc16_pkg::CHAR_LOWER_A && ch <= mcrc16_pkg::CHAR_LOWER_F) begin
            return 4'(ch - mcrc16_pkg::CHAR_LOWER_A + 8'd10);
         end
         ok = 1'b0;
         return 4'd0;
      endfunction

      function logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
         logic [15:0] acc;
         acc = crc ^ {8'd0, data};
         for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ mcrc16_pkg::CRC_POLY) : (acc >> 1);
         end
         return acc;
      endfunction

      function logic [6:0] nibble_text(input logic [3:0] n);
         logic [7:0] code;
         code = (n < 4'd10) ? (mcrc16_pkg::CHAR_ZERO + {4'd0, n})
                            : (mcrc16_pkg::CHAR_LOWER_A + {4'd0, n} - 8'd10);
         return code[6:0];
      endfunction

      function void note_char(input logic [7:0] ch, input logic last);
         logic [3:0]     nib;
         bit             ok;
         crc_result_type res;
         nib = digit_value(ch, ok);
         if (!ok) begin
            bad_seen = 1'b1;
         end
         if (!low_next) begin
            high_nibble = nib;
            low_next    = 1'b1;
         end else begin
            crc_acc     = crc_update(crc_acc, {high_nibble, nib});
            high_nibble = 4'd0;
            low_next    = 1'b0;
         end
         if (last) begin
            res.crc_value  = crc_acc;
            res.text_char0 = nibble_text(crc_acc[7:4]);
            res.text_char1 = nibble_text(crc_acc[3:0]);
            res.text_char2 = nibble_text(crc_acc[15:12]);
            res.text_char3 = nibble_text(crc_acc[11:8]);
            res.bad_digit  = bad_seen;
            res.odd_count  = low_next;
            crc_results_q.push_back(res);
            clear_message();
         end
      endfunction

      function void compare_field(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(input crc_result_type got);
         crc_result_type want;
         if (crc_results_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual %0h", $time, got);
            return;
         end
         want = crc_results_q.pop_front();
         compare_field("crc_value", want.crc_value, got.crc_value);
         compare_field("text_char0", 16'(want.text_char0), 16'(got.text_char0));
         compare_field("text_char1", 16'(want.text_char1), 16'(got.text_char1));
         compare_field("text_char2", 16'(want.text_char2), 16'(got.text_char2));
         compare_field("text_char3", 16'(want.text_char3), 16'(got.text_char3));
         compare_field("bad_digit", 16'(want.bad_digit), 16'(got.bad_digit));
         compare_field("odd_count", 16'(want.odd_count), 16'(got.odd_count));
      endfunction
   endclass

   logic clock;
   logic reset;

   mcrc16_req_if req_bus ();
   mcrc16_rsp_if rsp_bus ();

   modbus_crc16_hex_ascii dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   crc_scoreboard sb;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            items_sent;
   int            hold_left;
   bit            hold_request;
   int            quiet_cycles;

   always #10 clock = ~clock;

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_char(req_bus.ascii_char, req_bus.last_char);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result('{rsp_bus.crc_value, rsp_bus.text_char0, rsp_bus.text_char1,
                              rsp_bus.text_char2, rsp_bus.text_char3, rsp_bus.bad_digit,
                              rsp_bus.odd_count});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.ascii_char <= ch;
      req_bus.last_char  <= last;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [7:0] n;
      n = 8'($urandom_range(15));
      if (n < 8'd10) begin
         return mcrc16_pkg::CHAR_ZERO + n;
      end
      return ($urandom_range(1) ? mcrc16_pkg::CHAR_UPPER_A : mcrc16_pkg::CHAR_LOWER_A)
             + n - 8'd10;
   endfunction

   task automatic send_message(input int len, input int noise_pct);
      logic [7:0] ch;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            ch = 8'($urandom_range(255));
         end else begin
            ch = random_hex_char();
         end
         send_item(ch, i == len - 1);
      end
   endtask

   task automatic send_random_message();
      int len;
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         len = 2 * $urandom_range(1, 8);
      end else if (pick < 93) begin
         len = $urandom_range(1, 17);
      end else begin
         len = $urandom_range(17, 40);
      end
      send_message(len, ($urandom_range(99) < 12) ? 25 : 0);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.crc_results_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_random(input int target);
      while (items_sent < target) begin
         send_random_message();
      end
      wait_drained();
   endtask

   initial begin
      sb                 = new();
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.ascii_char = 8'd0;
      req_bus.last_char  = 1'b0;
      rsp_bus.ready      = 1'b0;
      send_idle_pct      = 27;
      recv_idle_pct      = 69;
      items_sent         = 0;
      hold_left          = 0;
      hold_request       = 1'b0;
      quiet_cycles       = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("0");
      send_text("00");
      send_text("FF");
      send_text("ff");
      send_text("/:");
      send_text("@G");
      send_text("`g");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      send_text("1a2");
      send_text("C7d8");
      wait_drained();

      // stall the result side while short messages keep arriving
      hold_request = 1'b1;
      for (int i = 0; i < 16; i++) begin
         send_message($urandom_range(1, 2), 0);
      end
      wait_drained();

      run_random(520);
      send_idle_pct = 69;
      recv_idle_pct = 27;
      run_random(1040);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(1550);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.crc_results_q.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d results never arrived", $time, sb.crc_results_q.size());
      end
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/mcrc16_pkg.sv
rtl/mcrc16_if.sv
rtl/mcrc16_step.sv
rtl/modbus_crc16_hex_ascii.sv
tb/tb_top.sv
